// ----- rtl/core/adt_pkg.sv -----
`default_nettype none

package adt_pkg;

   // Default table depth
   localparam int TABLE_SIZE_DEFAULT = 16;

   // Field widths
   localparam int REQ_TYPE_W = 2;
   localparam int ID_W       = 8;
   localparam int ADDR_W     = 48;
   localparam int STATUS_W   = 3;
   // Slot numbers travel at the width of the largest table (256 entries)
   localparam int SLOT_W     = 8;

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_ADD_LOCAL = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_ADD_ID    = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE    = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_LOOKUP    = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ADDR_PRESENT = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ID_PRESENT   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL         = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND    = 3'd4;

   // What one pass over the table found
   typedef struct packed {
      logic              addr_hit;
      logic              id_hit;
      logic              free_hit;
      logic [SLOT_W-1:0] id_slot;
      logic [SLOT_W-1:0] free_slot;
      logic [ID_W-1:0]   hit_ident;
   } scan_result_type;

endpackage

`default_nettype wire

// ----- rtl/core/adt_if.sv -----
`default_nettype none

// Request channel
interface adt_req_if import adt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [ID_W-1:0]       path_id;
   logic [ADDR_W-1:0]     endpoint_address;

   modport source (output valid, req_type, path_id, endpoint_address, input ready);
   modport sink   (input valid, req_type, path_id, endpoint_address, output ready);
endinterface

// Response channel
interface adt_rsp_if import adt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     result_id;

   modport source (output valid, status, result_id, input ready);
   modport sink   (input valid, status, result_id, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/address_id_table_top.sv -----
// Flow: a request beat starts a scan over every table entry, reading one entry
// per cycle through the single read port of the entry memory; the response
// register loads once the scan is complete and the register is free. A new
// request is taken only after that, never while a scan is in progress.
// Reset: synchronous, active high; clears all valid bits, the local id counter
// and the response valid flag. Table contents are not cleared.
`default_nettype none

module address_id_table_top import adt_pkg::*; #(
   parameter int TABLE_SIZE = TABLE_SIZE_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   adt_req_if.sink   req_if,
   adt_rsp_if.source rsp_if
);

   localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

   // Sequencer states
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;
   logic                  cmp_pend_ff;
   logic [IDX_W-1:0]      cmp_idx_ff;
   logic [TABLE_SIZE-1:0] valid_ff, valid_in;
   logic [ID_W-1:0]       next_id_ff, next_id_in;

   logic [REQ_TYPE_W-1:0] op_ff;
   logic [ID_W-1:0]       key_id_ff;
   logic [ADDR_W-1:0]     key_addr_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [ID_W-1:0]       result_id_ff, result_id_in;

   logic                  req_fire, commit;
   logic                  mem_wr;
   logic [ID_W-1:0]       rd_ident;
   logic [ADDR_W-1:0]     rd_endpoint;
   scan_result_type       scan;

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign commit       = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_if.ready);

   // Latch the request; the key id depends on the request type
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff       <= req_if.req_type;
         key_addr_ff <= req_if.endpoint_address;
         key_id_ff   <= (req_if.req_type == REQ_ADD_LOCAL) ? next_id_ff : req_if.path_id;
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (req_fire) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (cnt_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DRAIN: state_in = S_DONE;
         S_DONE: begin
            if (commit) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cnt_ff      <= '0;
         cmp_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         cmp_pend_ff <= (state_ff == S_SCAN);
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= cnt_ff;
   end

   // Entry storage
   adt_entry_mem #(
      .DEPTH (TABLE_SIZE),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock       (clock),
      .wr_en       (mem_wr),
      .wr_idx      (scan.free_slot[IDX_W-1:0]),
      .wr_ident    (key_id_ff),
      .wr_endpoint (key_addr_ff),
      .rd_en       (state_ff == S_SCAN),
      .rd_idx      (cnt_ff),
      .rd_ident    (rd_ident),
      .rd_endpoint (rd_endpoint)
   );

   // Compare and accumulate
   adt_scan_unit #(
      .IDX_W (IDX_W)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .start         (req_fire),
      .step          (cmp_pend_ff),
      .slot_idx      (cmp_idx_ff),
      .slot_valid    (valid_ff[cmp_idx_ff]),
      .slot_ident    (rd_ident),
      .slot_endpoint (rd_endpoint),
      .key_id        (key_id_ff),
      .key_addr      (key_addr_ff),
      .result        (scan)
   );

   // Decide the outcome once the scan is complete
   always_comb begin
      valid_in     = valid_ff;
      next_id_in   = next_id_ff;
      mem_wr       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      status_in    = status_ff;
      result_id_in = result_id_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
         status_in    = ST_OK;
         result_id_in = '0;
         case (op_ff)
            REQ_ADD_LOCAL, REQ_ADD_ID: begin
               if (scan.addr_hit) begin
                  status_in = ST_ADDR_PRESENT;
               end else if (scan.id_hit) begin
                  status_in = ST_ID_PRESENT;
               end else if (!scan.free_hit) begin
                  status_in = ST_FULL;
               end else begin
                  mem_wr = 1'b1;
                  valid_in[scan.free_slot[IDX_W-1:0]] = 1'b1;
                  if (op_ff == REQ_ADD_LOCAL) begin
                     result_id_in = key_id_ff;
                     next_id_in   = next_id_ff + 1'b1;
                  end
               end
            end
            REQ_REMOVE: begin
               if (scan.id_hit) begin
                  valid_in[scan.id_slot[IDX_W-1:0]] = 1'b0;
               end else begin
                  status_in = ST_NOT_FOUND;
               end
            end
            REQ_LOOKUP: begin
               if (scan.addr_hit) begin
                  result_id_in = scan.hit_ident;
               end else begin
                  status_in = ST_NOT_FOUND;
               end
            end
            default: status_in = ST_NOT_FOUND;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         next_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      result_id_ff <= result_id_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.status    = status_ff;
   assign rsp_if.result_id = result_id_ff;

endmodule

`default_nettype wire

// ----- rtl/core/adt_entry_mem.sv -----
`default_nettype none

module adt_entry_mem import adt_pkg::*; #(
   parameter int DEPTH = TABLE_SIZE_DEFAULT,
   parameter int IDX_W = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [IDX_W-1:0]  wr_idx,
   input  wire logic [ID_W-1:0]   wr_ident,
   input  wire logic [ADDR_W-1:0] wr_endpoint,
   input  wire logic              rd_en,
   input  wire logic [IDX_W-1:0]  rd_idx,
   output logic      [ID_W-1:0]   rd_ident,
   output logic      [ADDR_W-1:0] rd_endpoint
);

   logic [ID_W-1:0]   ident_mem    [DEPTH];
   logic [ADDR_W-1:0] endpoint_mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ident_mem[wr_idx]    <= wr_ident;
         endpoint_mem[wr_idx] <= wr_endpoint;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ident    <= ident_mem[rd_idx];
         rd_endpoint <= endpoint_mem[rd_idx];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/adt_scan_unit.sv -----
`default_nettype none

module adt_scan_unit import adt_pkg::*; #(
   parameter int IDX_W = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              step,
   input  wire logic [IDX_W-1:0]  slot_idx,
   input  wire logic              slot_valid,
   input  wire logic [ID_W-1:0]   slot_ident,
   input  wire logic [ADDR_W-1:0] slot_endpoint,
   input  wire logic [ID_W-1:0]   key_id,
   input  wire logic [ADDR_W-1:0] key_addr,
   output scan_result_type        result
);

   scan_result_type res_ff, res_in;
   logic            addr_eq, id_eq;

   // Shared comparator: one table entry per beat
   assign addr_eq = slot_valid && (slot_endpoint == key_addr);
   assign id_eq   = slot_valid && (slot_ident == key_id);

   always_comb begin
      res_in = res_ff;
      if (start) begin
         res_in = '0;
      end else if (step) begin
         if (addr_eq) begin
            res_in.addr_hit  = 1'b1;
            res_in.hit_ident = slot_ident;
         end
         if (id_eq) begin
            res_in.id_hit  = 1'b1;
            res_in.id_slot = SLOT_W'(slot_idx);
         end
         // keep the lowest free slot
         if (!slot_valid && !res_ff.free_hit) begin
            res_in.free_hit  = 1'b1;
            res_in.free_slot = SLOT_W'(slot_idx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
      end else begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

`default_nettype wire

// ----- rtl/core/adt_checker.sv -----
`default_nettype none

module adt_checker import adt_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [STATUS_W-1:0] status,
   input wire logic [ID_W-1:0]     result_id
);

   // A stalled response beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(result_id))
      else $error("response changed while stalled");

   // Only defined status codes leave the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (status <= ST_NOT_FOUND))
      else $error("undefined status code");

   // Failed requests carry no id
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status != ST_OK) |-> (result_id == '0))
      else $error("nonzero id on failed request");

   // The table is busy scanning right after a request beat
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while scan in progress");

endmodule

bind address_id_table_top adt_checker u_adt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .status    (rsp_if.status),
   .result_id (rsp_if.result_id)
);

`default_nettype wire

// ----- test/adt_checker.sv -----
`default_nettype none

// Watches both channels, keeps its own copy of the id table, predicts one
// response per request beat and compares every response beat with it.
module adt_scoreboard import adt_pkg::*; #(
   parameter int TABLE_SIZE = TABLE_SIZE_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   adt_req_if              req_mon,
   adt_rsp_if              rsp_mon,
   output int              errors,
   output int              pending,
   output logic [ID_W-1:0] local_id_next,
   output logic [255:0]    ids_in_use
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     result_id;
   } table_reply_type;

   // Shadow table
   logic              slot_used     [TABLE_SIZE];
   logic [ID_W-1:0]   slot_ident    [TABLE_SIZE];
   logic [ADDR_W-1:0] slot_endpoint [TABLE_SIZE];

   // Responses still owed by the block, oldest first
   table_reply_type replies_due [$];

   initial errors = 0;

   task automatic report_mismatch(input string what);
      errors++;
      $display("%0t: mismatch: %s", $time, what);
   endtask

   function automatic int slot_of_endpoint(input logic [ADDR_W-1:0] a);
      for (int i = 0; i < TABLE_SIZE; i++)
         if (slot_used[i] && slot_endpoint[i] == a) return i;
      return -1;
   endfunction

   function automatic int slot_of_ident(input logic [ID_W-1:0] id);
      for (int i = 0; i < TABLE_SIZE; i++)
         if (slot_used[i] && slot_ident[i] == id) return i;
      return -1;
   endfunction

   // Address check first, then id, then room; the lowest free slot is taken
   function automatic logic [STATUS_W-1:0] insert_entry(input logic [ID_W-1:0]   id,
                                                        input logic [ADDR_W-1:0] a);
      int free_slot = -1;
      if (slot_of_endpoint(a) >= 0) return ST_ADDR_PRESENT;
      if (slot_of_ident(id) >= 0) return ST_ID_PRESENT;
      for (int i = TABLE_SIZE - 1; i >= 0; i--)
         if (!slot_used[i]) free_slot = i;
      if (free_slot < 0) return ST_FULL;
      slot_used[free_slot]     = 1'b1;
      slot_ident[free_slot]    = id;
      slot_endpoint[free_slot] = a;
      return ST_OK;
   endfunction

   function automatic table_reply_type serve_request(input logic [REQ_TYPE_W-1:0] kind,
                                                     input logic [ID_W-1:0]       id,
                                                     input logic [ADDR_W-1:0]     a);
      table_reply_type r;
      int slot;
      r.status    = ST_OK;
      r.result_id = '0;
      case (kind)
         REQ_ADD_LOCAL: begin
            r.status = insert_entry(local_id_next, a);
            // counter moves only on success, wrapping at 256
            if (r.status == ST_OK) begin
               r.result_id   = local_id_next;
               local_id_next = local_id_next + 1'b1;
            end
         end
         REQ_ADD_ID: begin
            r.status = insert_entry(id, a);
         end
         REQ_REMOVE: begin
            slot = slot_of_ident(id);
            if (slot >= 0) slot_used[slot] = 1'b0;
            else r.status = ST_NOT_FOUND;
         end
         default: begin
            slot = slot_of_endpoint(a);
            if (slot >= 0) r.result_id = slot_ident[slot];
            else r.status = ST_NOT_FOUND;
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      table_reply_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_SIZE; i++) slot_used[i] = 1'b0;
         local_id_next = '0;
         replies_due.delete();
      end else begin
         // response beat against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (replies_due.size() == 0) begin
               report_mismatch($sformatf("response with nothing due: status %0d result_id %0d",
                                         rsp_mon.status, rsp_mon.result_id));
            end else begin
               want = replies_due.pop_front();
               if (rsp_mon.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_mon.status, want.status));
               if (rsp_mon.result_id !== want.result_id)
                  report_mismatch($sformatf("result_id %0d, expected %0d",
                                            rsp_mon.result_id, want.result_id));
            end
         end
         // request beat updates the shadow table
         if (req_mon.valid && req_mon.ready)
            replies_due.insert(replies_due.size(),
                               serve_request(req_mon.req_type, req_mon.path_id,
                                             req_mon.endpoint_address));
      end
      pending    = replies_due.size();
      ids_in_use = '0;
      for (int i = 0; i < TABLE_SIZE; i++)
         if (slot_used[i]) ids_in_use[slot_ident[i]] = 1'b1;
   end

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`default_nettype none

module tb import adt_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = TABLE_SIZE_DEFAULT;
   localparam int HOLD_CYCLES = 300;
   localparam int ADDR_POOL   = 32;
   localparam int IDENT_POOL  = 24;

   logic clock;
   logic reset;

   adt_req_if req_bus ();
   adt_rsp_if rsp_bus ();

   int              errors;
   int              pending;
   logic [ID_W-1:0] local_id_next;
   logic [255:0]    ids_in_use;

   int   send_idle_pct;
   int   recv_idle_pct;
   logic hold_rsp;

   logic [ADDR_W-1:0] addr_pool  [ADDR_POOL];
   logic [ID_W-1:0]   ident_pool [IDENT_POOL];

   address_id_table_top #(.TABLE_SIZE(DEPTH)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   adt_scoreboard #(.TABLE_SIZE(DEPTH)) u_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .errors        (errors),
      .pending       (pending),
      .local_id_next (local_id_next),
      .ids_in_use    (ids_in_use)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #5ms;
      $display("CHECK FAILED");
      $finish;
   end

   // Response side: random back-pressure, plus one long hold-off on request
   initial begin
      bit hold_done;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic [ADDR_W-1:0] fresh_address();
      return {$urandom(), 16'($urandom())};
   endfunction

   // One request beat; valid stays high into the next beat unless a gap is drawn
   task automatic send_request(input logic [REQ_TYPE_W-1:0] kind,
                               input logic [ID_W-1:0]       id,
                               input logic [ADDR_W-1:0]     a);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid            <= 1'b1;
      req_bus.req_type         <= kind;
      req_bus.path_id          <= id;
      req_bus.endpoint_address <= a;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic wait_for_replies();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Requests drawn from small pools so that hits, duplicates and a full table happen
   task automatic send_mixed(input int count);
      int                roll;
      logic [ID_W-1:0]   id;
      logic [ADDR_W-1:0] a;
      repeat (count) begin
         roll = $urandom_range(99);
         id   = ($urandom_range(7) == 0) ? ID_W'($urandom())
                                         : ident_pool[$urandom_range(IDENT_POOL - 1)];
         a    = ($urandom_range(7) == 0) ? fresh_address()
                                         : addr_pool[$urandom_range(ADDR_POOL - 1)];
         if (roll < 25)      send_request(REQ_ADD_LOCAL, id, a);
         else if (roll < 55) send_request(REQ_ADD_ID, id, a);
         else if (roll < 80) send_request(REQ_REMOVE, id, a);
         else                send_request(REQ_LOOKUP, id, a);
      end
   endtask

   // Local allocation with removals behind it, long enough for the counter to wrap.
   // Starts from an empty table and leaves it empty.
   task automatic churn_local_ids(input int count);
      logic [ID_W-1:0]   live_id   [$];
      logic [ADDR_W-1:0] live_addr [$];
      logic [ID_W-1:0]   counter;
      logic [ADDR_W-1:0] a;
      int                roll;
      int                pick;
      counter = local_id_next;
      repeat (count) begin
         roll = $urandom_range(99);
         pick = (live_id.size() > 0) ? $urandom_range(live_id.size() - 1) : 0;
         if (live_id.size() > 0 && roll < 15) begin
            send_request(REQ_LOOKUP, ID_W'($urandom()), live_addr[pick]);
         end else if (live_id.size() > 0 && roll < 20) begin
            // address already stored: rejected, counter holds
            send_request(REQ_ADD_LOCAL, ID_W'($urandom()), live_addr[pick]);
         end else if (live_id.size() > 0 &&
                      (roll < 50 || (live_id.size() == DEPTH && roll < 85))) begin
            send_request(REQ_REMOVE, live_id[pick], fresh_address());
            live_id.delete(pick);
            live_addr.delete(pick);
         end else begin
            a = fresh_address();
            send_request(REQ_ADD_LOCAL, ID_W'($urandom()), a);
            // a full table rejects it and the counter holds
            if (live_id.size() < DEPTH) begin
               live_id.insert(live_id.size(), counter);
               live_addr.insert(live_addr.size(), a);
               counter++;
            end
         end
      end
      while (live_id.size() > 0) begin
         send_request(REQ_REMOVE, live_id.pop_front(), fresh_address());
         void'(live_addr.pop_front());
      end
   endtask

   // Stimulus
   initial begin
      req_bus.valid            = 1'b0;
      req_bus.req_type         = REQ_ADD_LOCAL;
      req_bus.path_id          = '0;
      req_bus.endpoint_address = '0;
      hold_rsp                 = 1'b0;
      send_idle_pct            = 38;
      recv_idle_pct            = 65;

      // pools with the extremes up front; entry 5 shares its IPv4 part with entry 4
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      addr_pool[2] = {32'hFFFF_FFFF, 16'h0000};
      addr_pool[3] = {32'h0000_0000, 16'hFFFF};
      for (int i = 4; i < ADDR_POOL; i++) addr_pool[i] = fresh_address();
      addr_pool[5] = {addr_pool[4][ADDR_W-1:16], 16'($urandom())};
      ident_pool[0] = 8'd0;
      ident_pool[1] = 8'd255;
      ident_pool[2] = 8'd128;
      ident_pool[3] = 8'd1;
      for (int i = 4; i < IDENT_POOL; i++) ident_pool[i] = ID_W'($urandom());

      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, local counter at zero
      send_request(REQ_LOOKUP, 8'd0, '0);                          // not found
      send_request(REQ_REMOVE, 8'd0, '1);                          // not found
      send_request(REQ_ADD_LOCAL, 8'd255, '0);                     // ok, id 0
      send_request(REQ_ADD_LOCAL, 8'd0, '0);                       // address present
      send_request(REQ_ADD_ID, 8'd1, '1);                          // ok
      send_request(REQ_ADD_LOCAL, 8'd0, {32'hFFFF_FFFF, 16'h0});   // counter hits id 1
      send_request(REQ_ADD_ID, 8'd255, '0);                        // address present
      send_request(REQ_ADD_ID, 8'd0, {32'hFFFF_FFFF, 16'h0});      // id present
      send_request(REQ_LOOKUP, 8'd255, '1);                        // ok, id 1
      send_request(REQ_REMOVE, 8'd1, '0);                          // ok
      send_request(REQ_REMOVE, 8'd1, '0);                          // already gone
      send_request(REQ_LOOKUP, 8'd0, '1);                          // not found
      send_request(REQ_ADD_LOCAL, 8'd170, {32'hFFFF_FFFF, 16'h0}); // ok, id 1
      // fill the remaining slots, then overflow both kinds of add
      for (int j = 0; j < DEPTH - 2; j++)
         send_request(REQ_ADD_ID, 8'(255 - j), {32'h0A00_0000 + 32'(j), 16'(j)});
      send_request(REQ_ADD_ID, 8'd100, {32'h5555_5555, 16'hAAAA});
      send_request(REQ_ADD_LOCAL, 8'd85, {32'hAAAA_AAAA, 16'h5555});

      send_mixed(250);
      wait_for_replies();

      // second phase: idling swapped; empty the table, then run the counter round
      send_idle_pct = 65;
      recv_idle_pct = 38;
      for (int i = 0; i < 256; i++)
         if (ids_in_use[i]) send_request(REQ_REMOVE, ID_W'(i), fresh_address());
      churn_local_ids(800);
      wait_for_replies();

      // last phase: no idling, starting under a long response hold-off
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_rsp      = 1'b1;
      send_mixed(220);
      wait_for_replies();
      repeat (4 * DEPTH + 8) @(posedge clock);

      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
